@@ hw/rtl/trilinear_subcell_weights_assert.svh @@
// Assertion macros for the trilinear weight RTL.
// Needs nothing else; include it before the modules that assert.
`ifndef TRILINEAR_SUBCELL_WEIGHTS_ASSERT_SVH
`define TRILINEAR_SUBCELL_WEIGHTS_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TSW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trilinear weights: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define TSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trilinear weights: next-cycle check failed");

`endif

@@ hw/rtl/tsw_pkg.sv @@
// Types and constants of the trilinear cell weight block.
// Depends on nothing; imported by trilinear_subcell_weights.
package tsw_pkg;

  localparam int GRID_CELLS_MAX = 1024;
  localparam int FRAC_BITS      = 16;
  localparam int NODE_W         = 10;
  localparam int CELLS_W        = 11;
  localparam int W_W            = FRAC_BITS + 1;
  localparam int POS_W          = 32;
  localparam int INV_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int NCORNER        = 8;

  localparam logic [W_W-1:0] ONE_W  = W_W'(1) << FRAC_BITS;
  localparam logic [W_W-1:0] HALF_W = W_W'(1) << (FRAC_BITS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_INV_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 3'd5;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } tsw_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_x;
    logic [NODE_W-1:0] node_y;
    logic [NODE_W-1:0] node_z;
    logic [W_W-1:0]    weight;
    logic              last;
  } tsw_out_t;

  typedef struct packed {
    logic [NODE_W-1:0] lo;
    logic [NODE_W-1:0] hi;
  } tsw_node_t;

  typedef struct packed {
    tsw_node_t      node;
    logic [W_W-1:0] frac;
  } tsw_axis_t;

endpackage

@@ hw/rtl/trilinear_subcell_weights.sv @@
// Trilinear cloud-in-cell weights: one point in, up to eight weighted nodes out.
// Depends on tsw_pkg and trilinear_subcell_weights_assert.svh.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_stall, in_data      | point in
//  output  | out_valid, out_stall, out_data   | node out
//  config  | cfg_we, cfg_index, cfg_data      | write in
//
// Five register stages: scale multiply, axis clamp/fraction, xy products,
// xyz products, then a corner buffer that feeds the output register.
// A point enters in one transfer; its n nonzero corners (1 to 8, usually 8)
// leave one per cycle while the output is not stalled, so the output register
// sets the rate.
// Reset clears all valid bits and restores the register defaults.
// A stall on the output fills the stages back to the input; nothing is lost.
`include "trilinear_subcell_weights_assert.svh"

module trilinear_subcell_weights
  import tsw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tsw_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tsw_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [INV_W-1:0]   inv_x, inv_y, inv_z;
  logic [CELLS_W-1:0] cells_x, cells_y, cells_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_x   <= INV_W'(65536);
      inv_y   <= INV_W'(65536);
      inv_z   <= INV_W'(65536);
      cells_x <= CELLS_W'(1024);
      cells_y <= CELLS_W'(1024);
      cells_z <= CELLS_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_X:   inv_x   <= cfg_data[INV_W-1:0];
        REG_INV_Y:   inv_y   <= cfg_data[INV_W-1:0];
        REG_INV_Z:   inv_z   <= cfg_data[INV_W-1:0];
        REG_CELLS_X: cells_x <= cfg_data[CELLS_W-1:0];
        REG_CELLS_Y: cells_y <= cfg_data[CELLS_W-1:0];
        REG_CELLS_Z: cells_z <= cfg_data[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Index of the last node in use, with zero counts read as one node.
  function automatic logic [NODE_W-1:0] last_node(input logic [CELLS_W-1:0] c);
    logic [CELLS_W-1:0] d;
    d = c - CELLS_W'(1);
    if (c == '0) begin
      return '0;
    end else if (c > CELLS_W'(GRID_CELLS_MAX)) begin
      return NODE_W'(GRID_CELLS_MAX - 1);
    end else begin
      return d[NODE_W-1:0];
    end
  endfunction

  // Low/high node and saturated fraction from a Q32.32 scaled position.
  function automatic tsw_axis_t do_axis(input logic [63:0] s,
                                        input logic [NODE_W-1:0] nm1);
    tsw_axis_t         r;
    logic [NODE_W:0]   lo_inc;
    logic [32:0]       up;
    if (s[63]) begin
      r.node.lo = '0;
    end else if (s[63:32] > {{(32-NODE_W){1'b0}}, nm1}) begin
      r.node.lo = nm1;
    end else begin
      r.node.lo = s[32+NODE_W-1:32];
    end
    lo_inc = {1'b0, r.node.lo} + (NODE_W+1)'(1);
    r.node.hi = (lo_inc > {1'b0, nm1}) ? nm1 : lo_inc[NODE_W-1:0];
    // The low word of the difference is the low word of s; only the
    // integer part needs the subtract.
    up = {s[63], s[63:32]} - {{(33-NODE_W){1'b0}}, r.node.lo};
    if (up[32] || (up == '0 && s[31:0] == '0)) begin
      r.frac = '0;
    end else if (up != '0) begin
      r.frac = ONE_W;
    end else begin
      r.frac = {1'b0, s[31:32-FRAC_BITS]};
    end
    return r;
  endfunction

  // Stage valid bits and the ready chain.
  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4, buf_ready;

  assign ready4   = !v4 || buf_ready;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  // Stage 1: scale by the reciprocal spacing.
  logic signed [64:0] prod_x, prod_y, prod_z;
  logic [63:0]        s1_x, s1_y, s1_z;

  assign prod_x = in_data.pos_x * $signed({1'b0, inv_x});
  assign prod_y = in_data.pos_y * $signed({1'b0, inv_y});
  assign prod_z = in_data.pos_z * $signed({1'b0, inv_z});

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      s1_x <= prod_x[63:0];
      s1_y <= prod_y[63:0];
      s1_z <= prod_z[63:0];
    end
  end

  // Stage 2: clamp, node indices and fractions.
  tsw_axis_t ax2_x, ax2_y, ax2_z;

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      ax2_x <= do_axis(s1_x, last_node(cells_x));
      ax2_y <= do_axis(s1_y, last_node(cells_y));
      ax2_z <= do_axis(s1_z, last_node(cells_z));
    end
  end

  // Stage 3: the four x-y partial weights, rounded to Q1.16.
  logic [3:0][W_W-1:0]  t_next, t3;
  logic [W_W-1:0]       fz3;
  tsw_node_t            n3_x, n3_y, n3_z;

  always_comb begin
    logic [W_W-1:0]     wa, wb;
    logic [2*W_W-1:0]   p;
    for (int j = 0; j < 4; j++) begin
      wa = j[1] ? ax2_x.frac : ONE_W - ax2_x.frac;
      wb = j[0] ? ax2_y.frac : ONE_W - ax2_y.frac;
      p  = wa * wb + {{W_W{1'b0}}, HALF_W};
      t_next[j] = p[FRAC_BITS+W_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      t3   <= t_next;
      fz3  <= ax2_z.frac;
      n3_x <= ax2_x.node;
      n3_y <= ax2_y.node;
      n3_z <= ax2_z.node;
    end
  end

  // Stage 4: the eight corner weights, in a-b-c order.
  logic [NCORNER-1:0][W_W-1:0] w_next, w4;
  tsw_node_t                   n4_x, n4_y, n4_z;

  always_comb begin
    logic [W_W-1:0]     wc;
    logic [2*W_W-1:0]   p;
    for (int k = 0; k < NCORNER; k++) begin
      wc = k[0] ? fz3 : ONE_W - fz3;
      p  = t3[k/2] * wc + {{W_W{1'b0}}, HALF_W};
      w_next[k] = p[FRAC_BITS+W_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && v3) begin
      w4   <= w_next;
      n4_x <= n3_x;
      n4_y <= n3_y;
      n4_z <= n3_z;
    end
  end

  // Corner buffer: the mask of corners still to send doubles as its valid.
  logic [NCORNER-1:0]          buf_mask, sel_oh, rest, load_mask;
  logic [NCORNER-1:0][W_W-1:0] buf_w;
  tsw_node_t                   buf_x, buf_y, buf_z;
  logic [2:0]                  sel_k;
  logic                        out_free, emit;

  always_comb begin
    for (int k = 0; k < NCORNER; k++) begin
      load_mask[k] = (w4[k] != '0);
    end
  end

  assign sel_oh = buf_mask & (~buf_mask + NCORNER'(1));
  assign rest   = buf_mask & ~sel_oh;

  always_comb begin
    sel_k = '0;
    for (int k = 0; k < NCORNER; k++) begin
      if (sel_oh[k]) sel_k = 3'(k);
    end
  end

  assign out_free  = !out_valid || !out_stall;
  assign emit      = (buf_mask != '0) && out_free;
  assign buf_ready = (buf_mask == '0) || (emit && rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_mask <= '0;
    end else if (buf_ready && v4) begin
      buf_mask <= load_mask;
    end else if (emit) begin
      buf_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_ready && v4) begin
      buf_w <= w4;
      buf_x <= n4_x;
      buf_y <= n4_y;
      buf_z <= n4_z;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.node_x <= sel_k[2] ? buf_x.hi : buf_x.lo;
      out_data.node_y <= sel_k[1] ? buf_y.hi : buf_y.lo;
      out_data.node_z <= sel_k[0] ? buf_z.hi : buf_z.lo;
      out_data.weight <= buf_w[sel_k];
      out_data.last   <= (rest == '0);
    end
  end

  // A result that is not the point's last leaves the rest of it in the buffer.
  `TSW_ASSERT_NOW(a_rest_held, clk, rst, out_valid && !out_data.last, buf_mask != '0)
  // Only nonzero weights up to one are sent.
  `TSW_ASSERT_NOW(a_weight_range, clk, rst, out_valid,
                  out_data.weight != '0 && out_data.weight <= ONE_W)
  // A point held back at stage four keeps its weights.
  `TSW_ASSERT_NEXT(a_stage4_hold, clk, rst, v4 && !buf_ready, v4 && $stable(w4))
  // The input is stalled only while every stage is occupied.
  `TSW_ASSERT_NOW(a_stall_full, clk, rst, in_stall, v1 && v2 && v3 && v4 && buf_mask != '0)

endmodule
